>>> rtl/core/abpt_pkg.sv
`default_nettype none

package abpt_pkg;

  localparam int ENTRIES     = 4096;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int IN_IDX_W    = 12;
  localparam int PROB_W      = 16;
  localparam int CNT_W       = 16;
  localparam int NUM_W       = 19;  // 4*d + (2n+3) and 2*(2n+3)
  localparam int Q_W         = 16;  // rounded quotient never exceeds 16 bits
  localparam int DCNT_W      = $clog2(Q_W);

  localparam logic [PROB_W-1:0] PROB_MAX    = 16'hFFFF;
  localparam logic [PROB_W-1:0] PROB_MIN    = 16'h0001;
  localparam logic [PROB_W-1:0] PROB_RESET  = 16'h8000;
  localparam logic [CNT_W-1:0]  LIMIT_RESET = 16'd255;

endpackage

`default_nettype wire

>>> rtl/core/adaptive_bit_probability_table.sv
`default_nettype none

// Adaptive bit-probability table: each request names an entry and the bit just
// seen; the entry's 16-bit probability moves toward the bit by 2d/(2n+3),
// rounded, and its hit count rises up to cfg_count_limit. After reset the
// table is cleared one entry per cycle with in_ready low (configuration
// writes are taken throughout). One request is in flight at a time and goes
// from acceptance to a result in the output register through ST_READ, in
// which the table data arrives and the divider is set up, ST_DIV for the
// restoring divider (one quotient bit per cycle) and ST_DONE for write-back.
// The next request is taken in the cycle after write-back at the earliest, so
// no new request is taken before the last one is written back. A result still
// waiting in the output register holds write-back of the next one.
module adaptive_bit_probability_table
  import abpt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [IN_IDX_W-1:0] in_entry_index,
  input  wire logic                in_observed_bit,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [PROB_W-1:0]        out_prob_before,
  output logic [PROB_W-1:0]        out_prob_after,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CNT_W-1:0]    cfg_count_limit
);

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_DIV, ST_DONE} state_t;

  // count in the upper half, probability in the lower half
  logic [CNT_W+PROB_W-1:0] mem [ENTRIES];
  logic [CNT_W+PROB_W-1:0] rd_data_r;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                bit_r, bit_nxt;
  logic [PROB_W-1:0]   p_r, p_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [NUM_W-1:0]    dvs_r, dvs_nxt;
  logic [NUM_W-1:0]    rem_r, rem_nxt;
  logic [Q_W-1:0]      qsh_r, qsh_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic [CNT_W-1:0]    limit_r;
  logic                out_valid_r, out_valid_nxt;
  logic [PROB_W-1:0]   out_before_r, out_before_nxt;
  logic [PROB_W-1:0]   out_after_r, out_after_nxt;

  logic                in_fire;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [CNT_W+PROB_W-1:0] mem_wdata;

  logic [PROB_W-1:0]   rd_p, rd_n, d;
  logic [NUM_W-1:0]    den, num;
  logic [NUM_W:0]      shifted, diff;
  logic [PROB_W:0]     sum;
  logic [PROB_W-1:0]   np;

  assign in_ready        = (state_r == ST_IDLE);
  assign in_fire         = in_valid && in_ready;
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_prob_before = out_before_r;
  assign out_prob_after  = out_after_r;

  assign rd_p = rd_data_r[PROB_W-1:0];
  assign rd_n = rd_data_r[CNT_W+PROB_W-1:PROB_W];

  always_comb begin
    d       = bit_r ? (PROB_MAX - rd_p) : rd_p;
    den     = {2'b00, rd_n, 1'b0} + NUM_W'(3);
    num     = {1'b0, d, 2'b00} + den;
    shifted = {rem_r, qsh_r[Q_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    sum     = {1'b0, p_r} + {1'b0, qsh_r};
    if (bit_r) begin
      np = sum[PROB_W] ? PROB_MAX : sum[PROB_W-1:0];
    end else begin
      np = (qsh_r >= p_r) ? PROB_MIN : (p_r - qsh_r);
    end
    if (np == '0) begin
      np = PROB_MIN;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    bit_nxt        = bit_r;
    p_nxt          = p_r;
    n_nxt          = n_r;
    dvs_nxt        = dvs_r;
    rem_nxt        = rem_r;
    qsh_nxt        = qsh_r;
    dcnt_nxt       = dcnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_before_nxt = out_before_r;
    out_after_nxt  = out_after_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = {n_r, np};
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {{CNT_W{1'b0}}, PROB_RESET};
        idx_nxt   = idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt   = in_entry_index[IDX_W-1:0];
          bit_nxt   = in_observed_bit;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        // rounded 2d/den taken as floor((4d + den) / (2 den))
        p_nxt     = rd_p;
        n_nxt     = rd_n;
        dvs_nxt   = {den[NUM_W-2:0], 1'b0};
        rem_nxt   = {{Q_W{1'b0}}, num[NUM_W-1:Q_W]};
        qsh_nxt   = num[Q_W-1:0];
        dcnt_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!diff[NUM_W]) begin
          rem_nxt = diff[NUM_W-1:0];
          qsh_nxt = {qsh_r[Q_W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[NUM_W-1:0];
          qsh_nxt = {qsh_r[Q_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(Q_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          mem_we         = 1'b1;
          mem_wdata      = {(n_r < limit_r) ? (n_r + CNT_W'(1)) : n_r, np};
          out_valid_nxt  = 1'b1;
          out_before_nxt = p_r;
          out_after_nxt  = np;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      rd_data_r <= mem[in_entry_index[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_count_limit;
      end
    end
    bit_r        <= bit_nxt;
    p_r          <= p_nxt;
    n_r          <= n_nxt;
    dvs_r        <= dvs_nxt;
    rem_r        <= rem_nxt;
    qsh_r        <= qsh_nxt;
    dcnt_r       <= dcnt_nxt;
    out_before_r <= out_before_nxt;
    out_after_r  <= out_after_nxt;
  end

endmodule

`default_nettype wire
